// ===== design/uec_pkg.sv =====
package uec_pkg;

   localparam int unsigned MaxBytes = 4;
   localparam int unsigned CountWidth = 3;

   localparam logic [7:0] CHAR_DOT       = 8'h2e;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_DASH      = 8'h2d;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   localparam logic [15:0][7:0] HEX_DIGITS = {
      8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
      8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_string;
      logic       last_of_string;
   } req_item_type;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
      logic                     error;
      logic                     end_of_string;
   } expansion_type;

   // {ok, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0_0000;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_name_char(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) ||
             (b >= 8'h41 && b <= 8'h5a) || b == 8'h3a || b == 8'h5f ||
             b == CHAR_DOT;
   endfunction

endpackage

// ===== design/uec_req_if.sv =====
interface uec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first_of_string;
   logic       last_of_string;

   modport source(output valid, in_byte, first_of_string, last_of_string, input ready);
   modport sink(input valid, in_byte, first_of_string, last_of_string, output ready);
endinterface

// ===== design/uec_rsp_if.sv =====
interface uec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       error;
   logic       last_of_run;
   logic       end_of_string;

   modport source(output valid, out_byte, error, last_of_run, end_of_string, input ready);
   modport sink(input valid, out_byte, error, last_of_run, end_of_string, output ready);
endinterface

// ===== design/unit_name_escape_codec_unit.sv =====
// Unit-name escape codec. Takes one request byte per cycle unless stalled and
// returns the escaped (csr direction 0) or unescaped (direction 1) bytes on
// rsp; requests pass through s1_item_ff, then the output buffer. A byte that
// escapes to \xHH occupies the output serializer until all its bytes are sent
// and holds off requests until its last byte is taken; the rate is one cycle
// per output byte while rsp.ready is high, set by the single-byte rsp output.
// Unescaping produces zero or one byte per request; a malformed or unfinished
// escape is reported as one error result on the string's last request.
module unit_name_escape_codec_unit (
   input  logic      clock,
   input  logic      reset,
   uec_req_if.sink   req,
   uec_rsp_if.source rsp,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);

   logic                   direction_ff;
   logic                   s1_valid_ff;
   uec_pkg::req_item_type  s1_item_ff;
   uec_pkg::expansion_type expansion;
   logic                   buf_ready;
   logic                   advance;
   logic                   load_valid;

   assign advance    = s1_valid_ff && buf_ready;
   assign load_valid = s1_valid_ff && (expansion.count != '0);
   assign req.ready  = !s1_valid_ff || buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            direction_ff <= csr_write_data;
         end
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_item_ff.in_byte         <= req.in_byte;
         s1_item_ff.first_of_string <= req.first_of_string;
         s1_item_ff.last_of_string  <= req.last_of_string;
      end
   end

   uec_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .direction (direction_ff),
      .advance   (advance),
      .item      (s1_item_ff),
      .expansion (expansion)
   );

   uec_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (expansion),
      .load_ready (buf_ready),
      .rsp        (rsp)
   );

endmodule

// ===== design/uec_xform.sv =====
module uec_xform (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  direction,
   input  logic                  advance,
   input  uec_pkg::req_item_type item,
   output uec_pkg::expansion_type expansion
);

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_BACKSLASH,
      PHASE_HIGH,
      PHASE_LOW
   } phase_type;

   phase_type  phase_ff, phase_in, phase_e;
   logic [3:0] nibble_ff, nibble_in, nibble_e;
   logic       sticky_ff, sticky_in, sticky_e;

   logic [7:0] b;
   logic [4:0] hv;
   logic       emit;
   logic       err;
   logic [7:0] ob;

   assign b  = item.in_byte;
   assign hv = uec_pkg::hex_decode(b);

   always_comb begin
      phase_e  = item.first_of_string ? PHASE_IDLE : phase_ff;
      nibble_e = item.first_of_string ? 4'h0 : nibble_ff;
      sticky_e = item.first_of_string ? 1'b0 : sticky_ff;
      phase_in  = phase_e;
      nibble_in = nibble_e;
      sticky_in = sticky_e;
      emit = 1'b0;
      err  = 1'b0;
      ob   = b;
      expansion = '0;

      if (!direction) begin
         if (b == uec_pkg::CHAR_SLASH) begin
            expansion.bytes[0] = uec_pkg::CHAR_DASH;
            expansion.count    = uec_pkg::CountWidth'(1);
         end else if ((item.first_of_string && b == uec_pkg::CHAR_DOT) ||
                      b == uec_pkg::CHAR_DASH || b == uec_pkg::CHAR_BACKSLASH ||
                      !uec_pkg::is_name_char(b)) begin
            expansion.bytes[0] = uec_pkg::CHAR_BACKSLASH;
            expansion.bytes[1] = uec_pkg::CHAR_LOWER_X;
            expansion.bytes[2] = uec_pkg::HEX_DIGITS[b[7:4]];
            expansion.bytes[3] = uec_pkg::HEX_DIGITS[b[3:0]];
            expansion.count    = uec_pkg::CountWidth'(uec_pkg::MaxBytes);
         end else begin
            expansion.bytes[0] = b;
            expansion.count    = uec_pkg::CountWidth'(1);
         end
         expansion.end_of_string = item.last_of_string;
      end else begin
         if (!sticky_e) begin
            case (phase_e)
               PHASE_IDLE: begin
                  if (b == uec_pkg::CHAR_BACKSLASH) begin
                     phase_in = PHASE_BACKSLASH;
                  end else begin
                     emit = 1'b1;
                     ob = (b == uec_pkg::CHAR_DASH) ? uec_pkg::CHAR_SLASH : b;
                  end
               end
               PHASE_BACKSLASH: begin
                  if (b == uec_pkg::CHAR_LOWER_X) begin
                     phase_in = PHASE_HIGH;
                  end else begin
                     sticky_in = 1'b1;
                  end
               end
               PHASE_HIGH: begin
                  if (hv[4]) begin
                     nibble_in = hv[3:0];
                     phase_in  = PHASE_LOW;
                  end else begin
                     sticky_in = 1'b1;
                  end
               end
               PHASE_LOW: begin
                  if (hv[4]) begin
                     emit = 1'b1;
                     ob = {nibble_e, hv[3:0]};
                     phase_in = PHASE_IDLE;
                  end else begin
                     sticky_in = 1'b1;
                  end
               end
               default: begin
                  sticky_in = 1'b1;
               end
            endcase
         end
         if (item.last_of_string) begin
            if (phase_in != PHASE_IDLE || sticky_in) begin
               emit = 1'b1;
               err  = 1'b1;
               ob   = uec_pkg::CHAR_NUL;
            end
         end
         expansion.bytes[0]      = ob;
         expansion.count         = emit ? uec_pkg::CountWidth'(1) : '0;
         expansion.error         = err;
         expansion.end_of_string = item.last_of_string;
      end

      if (item.last_of_string) begin
         phase_in  = PHASE_IDLE;
         nibble_in = 4'h0;
         sticky_in = 1'b0;
      end else if (!direction) begin
         phase_in  = phase_e;
         nibble_in = nibble_e;
         sticky_in = sticky_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         nibble_ff <= 4'h0;
         sticky_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

// ===== design/uec_out_buf.sv =====
module uec_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  uec_pkg::expansion_type load,
   output logic                   load_ready,
   uec_rsp_if.source              rsp
);

   logic [uec_pkg::MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [uec_pkg::CountWidth-1:0]    count_ff, count_in;
   logic                              error_ff, error_in;
   logic                              eos_ff, eos_in;
   logic                              pop;

   assign pop        = rsp.valid && rsp.ready;
   assign load_ready = (count_ff == '0) ||
                       (count_ff == uec_pkg::CountWidth'(1) && rsp.ready);

   assign rsp.valid         = (count_ff != '0);
   assign rsp.out_byte      = bytes_ff[0];
   assign rsp.error         = error_ff;
   assign rsp.last_of_run   = (count_ff == uec_pkg::CountWidth'(1));
   assign rsp.end_of_string = eos_ff && (count_ff == uec_pkg::CountWidth'(1));

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      error_in = error_ff;
      eos_in   = eos_ff;
      if (pop) begin
         for (int i = 0; i < uec_pkg::MaxBytes - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         bytes_in[uec_pkg::MaxBytes-1] = 8'h00;
         count_in = count_ff - uec_pkg::CountWidth'(1);
      end
      if (load_valid && load_ready) begin
         bytes_in = load.bytes;
         count_in = load.count;
         error_in = load.error;
         eos_in   = load.end_of_string;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      error_ff <= error_in;
      eos_ff   <= eos_in;
   end

   count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= uec_pkg::CountWidth'(uec_pkg::MaxBytes))
      else $error("output count out of range");

   error_form: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.error |-> rsp.last_of_run && rsp.end_of_string &&
      rsp.out_byte == uec_pkg::CHAR_NUL)
      else $error("error result not a lone final zero byte");

   drain_step: assert property (@(posedge clock) disable iff (reset)
      pop && count_ff > uec_pkg::CountWidth'(1) |=>
      count_ff == $past(count_ff) - uec_pkg::CountWidth'(1))
      else $error("expansion drained out of step");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

typedef enum logic {DIR_ESCAPE, DIR_UNESCAPE} direction_type;

typedef enum logic [1:0] {PH_IDLE, PH_BACKSLASH, PH_HIGH, PH_LOW} escape_phase_type;

typedef struct packed {
   logic [7:0] out_byte;
   logic       error;
   logic       last_of_run;
   logic       end_of_string;
} codec_result_type;

class unit_name_scoreboard;
   direction_type    direction;
   escape_phase_type phase;
   logic [3:0]       high_digit;
   logic             bad_escape;
   codec_result_type expected_bytes[$];
   int unsigned      mismatches;

   function new();
      direction  = DIR_ESCAPE;
      phase      = PH_IDLE;
      high_digit = 4'h0;
      bad_escape = 1'b0;
      mismatches = 0;
   endfunction

   function void clear_string();
      phase      = PH_IDLE;
      high_digit = 4'h0;
      bad_escape = 1'b0;
   endfunction

   function void expect_byte(logic [7:0] b, logic err, logic run_end, logic str_end);
      codec_result_type r;
      r.out_byte      = b;
      r.error         = err;
      r.last_of_run   = run_end;
      r.end_of_string = str_end;
      expected_bytes.push_back(r);
   endfunction

   function int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function void note_request(logic [7:0] b, logic is_first, logic is_last);
      int  v;
      bit  plain;
      if (is_first) clear_string();
      if (direction == DIR_ESCAPE) begin
         plain = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
                 (b >= "A" && b <= "Z") || b == ":" || b == "_" ||
                 b == uec_pkg::CHAR_DOT;
         if (b == uec_pkg::CHAR_SLASH) begin
            expect_byte(uec_pkg::CHAR_DASH, 1'b0, 1'b1, is_last);
         end else if ((is_first && b == uec_pkg::CHAR_DOT) || b == uec_pkg::CHAR_DASH ||
                      b == uec_pkg::CHAR_BACKSLASH || !plain) begin
            expect_byte(uec_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, 1'b0);
            expect_byte(uec_pkg::CHAR_LOWER_X, 1'b0, 1'b0, 1'b0);
            expect_byte(uec_pkg::HEX_DIGITS[b[7:4]], 1'b0, 1'b0, 1'b0);
            expect_byte(uec_pkg::HEX_DIGITS[b[3:0]], 1'b0, 1'b1, is_last);
         end else begin
            expect_byte(b, 1'b0, 1'b1, is_last);
         end
         if (is_last) clear_string();
         return;
      end
      if (!bad_escape) begin
         case (phase)
            PH_IDLE: begin
               if (b == uec_pkg::CHAR_BACKSLASH) phase = PH_BACKSLASH;
               else expect_byte(b == uec_pkg::CHAR_DASH ? uec_pkg::CHAR_SLASH : b,
                                1'b0, 1'b1, is_last);
            end
            PH_BACKSLASH: begin
               if (b == uec_pkg::CHAR_LOWER_X) phase = PH_HIGH;
               else bad_escape = 1'b1;
            end
            PH_HIGH: begin
               v = hex_value(b);
               if (v < 0) begin
                  bad_escape = 1'b1;
               end else begin
                  high_digit = 4'(v);
                  phase      = PH_LOW;
               end
            end
            default: begin
               v = hex_value(b);
               if (v < 0) begin
                  bad_escape = 1'b1;
               end else begin
                  expect_byte({high_digit, 4'(v)}, 1'b0, 1'b1, is_last);
                  phase = PH_IDLE;
               end
            end
         endcase
      end
      if (is_last) begin
         if (phase != PH_IDLE) bad_escape = 1'b1;
         if (bad_escape) expect_byte(uec_pkg::CHAR_NUL, 1'b1, 1'b1, 1'b1);
         clear_string();
      end
   endfunction

   function void check_response(codec_result_type got);
      codec_result_type want;
      if (expected_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result: byte %02h error %0b run_end %0b str_end %0b",
                     got.out_byte, got.error, got.last_of_run, got.end_of_string);
         end
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.error !== want.error ||
          got.last_of_run !== want.last_of_run ||
          got.end_of_string !== want.end_of_string) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected byte %02h error %0b run_end %0b str_end %0b",
                     want.out_byte, want.error, want.last_of_run, want.end_of_string);
            $display("          actual   byte %02h error %0b run_end %0b str_end %0b",
                     got.out_byte, got.error, got.last_of_run, got.end_of_string);
         end
      end
   endfunction
endclass

module tb_top;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   uec_req_if req_if();
   uec_rsp_if rsp_if();

   unit_name_escape_codec_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   unit_name_scoreboard board;
   int unsigned         accepted_requests;
   logic                quiet;
   logic                hold_rsp;
   logic [7:0]          str_buf[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_request(req_if.in_byte, req_if.first_of_string,
                               req_if.last_of_string);
            accepted_requests++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_response({rsp_if.out_byte, rsp_if.error, rsp_if.last_of_run,
                                  rsp_if.end_of_string});
         end
      end
   end

   initial begin : rsp_sink
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_if.ready = 1'b0;
         else if (quiet) rsp_if.ready = 1'b1;
         else rsp_if.ready = ($urandom_range(99) >= 29);
      end
   end

   // long output stall so the request side backs up
   initial begin : rsp_hold_off
      hold_rsp = 1'b0;
      wait (accepted_requests >= 160);
      hold_rsp = 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin : run_timeout
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_request(input logic [7:0] b, input logic f, input logic l);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 29) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid           = 1'b1;
      req_if.in_byte         = b;
      req_if.first_of_string = f;
      req_if.last_of_string  = l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_buf(input logic mark_first, input logic mark_last);
      for (int i = 0; i < str_buf.size(); i++) begin
         send_request(str_buf[i], mark_first && i == 0,
                      mark_last && i == str_buf.size() - 1);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (board.expected_bytes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_direction(input direction_type d);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data   = d;
      board.direction  = d;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [7:0] random_hex();
      int unsigned v;
      v = $urandom_range(15);
      if (v < 10) return "0" + 8'(v);
      if ($urandom_range(1) == 1) return "a" + 8'(v - 10);
      return "A" + 8'(v - 10);
   endfunction

   initial begin : stimulus
      direction_type phase_dirs [8];
      int unsigned   start_count;
      int unsigned   len;
      int unsigned   idx;
      logic [7:0]    c;
      logic          mf;
      logic          ml;

      phase_dirs = '{DIR_ESCAPE, DIR_UNESCAPE, DIR_ESCAPE, DIR_UNESCAPE,
                     DIR_UNESCAPE, DIR_ESCAPE, DIR_ESCAPE, DIR_UNESCAPE};
      board                  = new();
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = 1'b0;
      quiet                  = 1'b0;
      req_if.valid           = 1'b0;
      req_if.in_byte         = 8'h00;
      req_if.first_of_string = 1'b0;
      req_if.last_of_string  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // escape: leading dot, slash, dash, backslash, NUL, high byte, plain, inner dot
      str_buf = '{uec_pkg::CHAR_DOT, uec_pkg::CHAR_SLASH, uec_pkg::CHAR_DASH,
                  uec_pkg::CHAR_BACKSLASH, uec_pkg::CHAR_NUL, 8'hff, "Z",
                  uec_pkg::CHAR_DOT};
      send_buf(1'b1, 1'b1);
      str_buf = '{uec_pkg::CHAR_SLASH};
      send_buf(1'b1, 1'b1);

      write_direction(DIR_UNESCAPE);
      str_buf = '{uec_pkg::CHAR_BACKSLASH, uec_pkg::CHAR_LOWER_X, "4", "1",
                  uec_pkg::CHAR_DASH, uec_pkg::CHAR_BACKSLASH,
                  uec_pkg::CHAR_LOWER_X, "f", "F"};
      send_buf(1'b1, 1'b1);
      str_buf = '{uec_pkg::CHAR_BACKSLASH, "y", "a"};
      send_buf(1'b1, 1'b1);
      str_buf = '{uec_pkg::CHAR_BACKSLASH, uec_pkg::CHAR_LOWER_X, "g"};
      send_buf(1'b1, 1'b1);
      // unclosed string whose state is cleared by the next first, then an unfinished escape
      str_buf = '{"q"};
      send_buf(1'b1, 1'b0);
      str_buf = '{uec_pkg::CHAR_BACKSLASH, uec_pkg::CHAR_LOWER_X, "4"};
      send_buf(1'b1, 1'b1);
      // direction flip in the middle of an escape
      str_buf = '{uec_pkg::CHAR_BACKSLASH, uec_pkg::CHAR_LOWER_X};
      send_buf(1'b1, 1'b0);
      write_direction(DIR_ESCAPE);
      str_buf = '{"4"};
      send_buf(1'b0, 1'b0);
      write_direction(DIR_UNESCAPE);
      str_buf = '{"7", "e"};
      send_buf(1'b0, 1'b1);

      foreach (phase_dirs[p]) begin
         write_direction(phase_dirs[p]);
         quiet       = (p == 5);
         start_count = accepted_requests;
         while (accepted_requests - start_count < 40) begin
            str_buf.delete();
            if (phase_dirs[p] == DIR_ESCAPE) begin
               len = $urandom_range(1, 8);
               repeat (len) begin
                  case ($urandom_range(9))
                     0:       c = uec_pkg::CHAR_DOT;
                     1:       c = uec_pkg::CHAR_SLASH;
                     2:       c = uec_pkg::CHAR_DASH;
                     3:       c = uec_pkg::CHAR_BACKSLASH;
                     4:       c = uec_pkg::CHAR_NUL;
                     default: c = 8'($urandom_range(255));
                  endcase
                  str_buf.push_back(c);
               end
            end else begin
               len = $urandom_range(1, 5);
               repeat (len) begin
                  if ($urandom_range(99) < 45) begin
                     str_buf.push_back(uec_pkg::CHAR_BACKSLASH);
                     str_buf.push_back(uec_pkg::CHAR_LOWER_X);
                     str_buf.push_back(random_hex());
                     str_buf.push_back(random_hex());
                  end else begin
                     c = 8'($urandom_range(255));
                     if (c == uec_pkg::CHAR_BACKSLASH) c = uec_pkg::CHAR_DASH;
                     str_buf.push_back(c);
                  end
               end
               // corrupt or truncate some strings
               if ($urandom_range(99) < 20) begin
                  if ($urandom_range(1) == 1 && str_buf.size() > 1) begin
                     void'(str_buf.pop_back());
                  end else begin
                     idx = $urandom_range(str_buf.size() - 1);
                     str_buf[idx] = ($urandom_range(1) == 1) ? uec_pkg::CHAR_BACKSLASH
                                                             : 8'($urandom_range(255));
                  end
               end
            end
            mf = ($urandom_range(99) >= 8);
            ml = ($urandom_range(99) >= 8);
            send_buf(mf, ml);
         end
      end
      quiet = 1'b0;

      drain();
      if (board.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
